// ----- src/register_file_with_execute_ops_macros.svh -----
// ----------------------------------------------------------------------------
// register file with execute ops - assertion macros
// shared concurrent assertion forms used at the top level
// ----------------------------------------------------------------------------
`ifndef REGISTER_FILE_WITH_EXECUTE_OPS_MACROS_SVH
`define REGISTER_FILE_WITH_EXECUTE_OPS_MACROS_SVH

// same-cycle implication, disabled in reset
`define RFX_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RFX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rfx_pkg.sv -----
// ----------------------------------------------------------------------------
// rfx_pkg
// types, codes and defaults shared by the register file with execute ops
// ----------------------------------------------------------------------------
package rfx_pkg;

    localparam int NUM_REGS_DEFAULT  = 32;
    localparam int MEM_WORDS_DEFAULT = 1024;
    localparam int DATA_W            = 32;

    typedef enum logic [3:0] {
        OP_WRITE = 4'd0,
        OP_READ  = 4'd1,
        OP_STORE = 4'd2,
        OP_LOAD  = 4'd3,
        OP_ADDI  = 4'd4,
        OP_SLL   = 4'd5,
        OP_SRL   = 4'd6,
        OP_BEQ   = 4'd7,
        OP_BNE   = 4'd8,
        OP_JR    = 4'd9
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_RDB,
        ST_EXE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [3:0]         req_type;
        logic [5:0]         reg_a;
        logic [5:0]         reg_b;
        logic signed [31:0] operand_value;
        logic [4:0]         shift_amount;
        logic [9:0]         mem_address;
        logic [15:0]        branch_target;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic               branch_taken;
        logic [15:0]        target_address;
        logic               error;
    } rsp_t;

    typedef struct packed {
        logic load_req;
        logic mod_step;
        logic issue_a;
        logic capture_a;
        logic exec;
        logic clear_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic addr_high;
        logic clear_last;
    } status_t;

endpackage

// ----- src/rfx_req_if.sv -----
// ----------------------------------------------------------------------------
// rfx_req_if
// request channel: valid, ready and request fields
// ----------------------------------------------------------------------------
interface rfx_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         req_type;
    logic [5:0]         reg_a;
    logic [5:0]         reg_b;
    logic signed [31:0] operand_value;
    logic [4:0]         shift_amount;
    logic [9:0]         mem_address;
    logic [15:0]        branch_target;

    modport source (
        output valid, req_type, reg_a, reg_b, operand_value, shift_amount,
               mem_address, branch_target,
        input  ready
    );
    modport sink (
        input  valid, req_type, reg_a, reg_b, operand_value, shift_amount,
               mem_address, branch_target,
        output ready
    );
endinterface

// ----- src/rfx_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rfx_rsp_if
// result channel: valid, ready and result fields
// ----------------------------------------------------------------------------
interface rfx_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_data;
    logic               branch_taken;
    logic [15:0]        target_address;
    logic               error;

    modport source (
        output valid, read_data, branch_taken, target_address, error,
        input  ready
    );
    modport sink (
        input  valid, read_data, branch_taken, target_address, error,
        output ready
    );
endinterface

// ----- src/rfx_ram.sv -----
// ----------------------------------------------------------------------------
// rfx_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rfx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/rfx_ctrl.sv -----
// ----------------------------------------------------------------------------
// rfx_ctrl
// sequencer: memory clear after reset, request handshake, step control
// ----------------------------------------------------------------------------
module rfx_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  rfx_pkg::status_t status,
    output rfx_pkg::cmd_t    cmd
);

    rfx_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rfx_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            rfx_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = rfx_pkg::ST_IDLE;
                end
            end
            rfx_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = rfx_pkg::ST_ADDR;
                end
            end
            rfx_pkg::ST_ADDR:
            begin
                // fold the word address into the memory before the reads
                if (status.addr_high)
                begin
                    cmd.mod_step = 1'b1;
                end
                else
                begin
                    cmd.issue_a = 1'b1;
                    state_next  = rfx_pkg::ST_RDB;
                end
            end
            rfx_pkg::ST_RDB:
            begin
                cmd.capture_a = 1'b1;
                state_next    = rfx_pkg::ST_EXE;
            end
            rfx_pkg::ST_EXE:
            begin
                cmd.exec   = 1'b1;
                state_next = rfx_pkg::ST_OUT;
            end
            rfx_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = rfx_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rfx_pkg::ST_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- src/rfx_datapath.sv -----
// ----------------------------------------------------------------------------
// rfx_datapath
// request latch, register file and data memory, execute logic, result register
// ----------------------------------------------------------------------------
module rfx_datapath #(
    parameter int NUM_REGS  = rfx_pkg::NUM_REGS_DEFAULT,
    parameter int MEM_WORDS = rfx_pkg::MEM_WORDS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rfx_pkg::cmd_t    cmd,
    output rfx_pkg::status_t status,
    input  rfx_pkg::req_t    req,
    output rfx_pkg::rsp_t    rsp
);

    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int DW = rfx_pkg::DATA_W;

    // latched request
    rfx_pkg::op_t  op_reg;
    logic [5:0]    ra_reg;
    logic [5:0]    rb_reg;
    logic [DW-1:0] val_reg;
    logic [4:0]    sh_reg;
    logic [9:0]    addr_reg;
    logic [15:0]   tgt_reg;

    logic [DW-1:0] a_val_reg;
    logic [DW-1:0] mem_val_reg;
    logic [NUM_REGS-1:0] valid_reg, valid_next;
    logic [AW-1:0] clr_cnt_reg;
    rfx_pkg::rsp_t res_reg, res_next;
    rfx_pkg::rsp_t out_reg;

    logic [RW-1:0] ra_idx, rb_idx;
    logic [16:0]   addr_wide;
    logic [AW-1:0] mem_idx;
    logic          a_bad, b_bad;
    logic [DW-1:0] b_val;

    logic          rf_we, rf_re;
    logic [RW-1:0] rf_raddr;
    logic [DW-1:0] rf_wdata, rf_rdata;
    logic          dm_we;
    logic [AW-1:0] dm_waddr;
    logic [DW-1:0] dm_wdata, dm_rdata;

    assign ra_idx    = ra_reg[RW-1:0];
    assign rb_idx    = rb_reg[RW-1:0];
    assign addr_wide = 17'(addr_reg);
    assign mem_idx   = addr_wide[AW-1:0];
    assign a_bad     = {1'b0, ra_reg} >= 7'(NUM_REGS);
    assign b_bad     = {1'b0, rb_reg} >= 7'(NUM_REGS);

    assign status.addr_high  = addr_wide >= 17'(MEM_WORDS);
    assign status.clear_last = clr_cnt_reg == AW'(MEM_WORDS - 1);

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg   <= rfx_pkg::op_t'(req.req_type);
            ra_reg   <= req.reg_a;
            rb_reg   <= req.reg_b;
            val_reg  <= req.operand_value;
            sh_reg   <= req.shift_amount;
            addr_reg <= req.mem_address;
            tgt_reg  <= req.branch_target;
        end
        else if (cmd.mod_step)
        begin
            addr_reg <= addr_reg - 10'(MEM_WORDS);
        end
        if (cmd.capture_a)
        begin
            // a register never written reads as zero
            a_val_reg   <= valid_reg[ra_idx] ? rf_rdata : '0;
            mem_val_reg <= dm_rdata;
        end
        if (cmd.exec)
        begin
            res_reg <= res_next;
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    assign b_val = valid_reg[rb_idx] ? rf_rdata : '0;

    always_comb
    begin
        res_next   = '0;
        rf_we      = 1'b0;
        rf_wdata   = '0;
        dm_we      = 1'b0;
        dm_waddr   = mem_idx;
        dm_wdata   = a_val_reg;
        valid_next = valid_reg;

        if (cmd.exec)
        begin
            if (op_reg <= rfx_pkg::OP_JR && (a_bad ||
                ((op_reg == rfx_pkg::OP_BEQ || op_reg == rfx_pkg::OP_BNE) && b_bad)))
            begin
                res_next.error     = 1'b1;
                res_next.read_data = '1;
            end
            else
            begin
                unique case (op_reg)
                    rfx_pkg::OP_WRITE:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = val_reg;
                    end
                    rfx_pkg::OP_READ, rfx_pkg::OP_JR:
                    begin
                        res_next.read_data = a_val_reg;
                    end
                    rfx_pkg::OP_STORE:
                    begin
                        dm_we = 1'b1;
                    end
                    rfx_pkg::OP_LOAD:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = mem_val_reg;
                    end
                    rfx_pkg::OP_ADDI:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = a_val_reg + val_reg;
                    end
                    rfx_pkg::OP_SLL:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = a_val_reg << sh_reg;
                    end
                    rfx_pkg::OP_SRL:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = DW'($signed(a_val_reg) >>> sh_reg);
                    end
                    rfx_pkg::OP_BEQ:
                    begin
                        res_next.branch_taken = a_val_reg == b_val;
                    end
                    rfx_pkg::OP_BNE:
                    begin
                        res_next.branch_taken = a_val_reg != b_val;
                    end
                    default:
                    begin
                        // unused codes leave state alone and report zeros
                        res_next = '0;
                    end
                endcase
                if (res_next.branch_taken)
                begin
                    res_next.target_address = tgt_reg;
                end
            end
            if (rf_we)
            begin
                valid_next[ra_idx] = 1'b1;
            end
        end

        if (cmd.clear_step)
        begin
            dm_we    = 1'b1;
            dm_waddr = clr_cnt_reg;
            dm_wdata = '0;
        end
    end

    assign rf_re    = cmd.issue_a | cmd.capture_a;
    assign rf_raddr = cmd.issue_a ? ra_idx : rb_idx;

    rfx_ram #(
        .WIDTH (DW),
        .DEPTH (NUM_REGS)
    ) u_regs (
        .clk   (clk),
        .we    (rf_we),
        .waddr (ra_idx),
        .wdata (rf_wdata),
        .re    (rf_re),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    rfx_ram #(
        .WIDTH (DW),
        .DEPTH (MEM_WORDS)
    ) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (cmd.issue_a),
        .raddr (mem_idx),
        .rdata (dm_rdata)
    );

    assign rsp = out_reg;

endmodule

// ----- src/register_file_with_execute_ops.sv -----
// ----------------------------------------------------------------------------
// register_file_with_execute_ops
// register file and data memory executing one request per transfer
// ----------------------------------------------------------------------------
// After reset the data memory is cleared one word per cycle, and no request
// is taken until that pass ends. Each request then steps through the
// address, read, execute and output states before the next can be taken,
// with address folding steps while the address is MEM_WORDS or more (none
// when MEM_WORDS is 1024 or more). The sequence is set by the single read
// port of the register file ram: the first register and the memory word are
// read, then the second register, then the operation executes and writes
// back. The result sits in an output register, so a new request is taken
// while it waits; a further result is held until that one is transferred.
module register_file_with_execute_ops #(
    parameter int NUM_REGS  = rfx_pkg::NUM_REGS_DEFAULT,
    parameter int MEM_WORDS = rfx_pkg::MEM_WORDS_DEFAULT
) (
    input logic   clk,
    input logic   rst_n,
    rfx_req_if.sink   req,
    rfx_rsp_if.source rsp
);

`include "register_file_with_execute_ops_macros.svh"

    rfx_pkg::cmd_t    cmd;
    rfx_pkg::status_t status;
    rfx_pkg::req_t    req_data;
    rfx_pkg::rsp_t    rsp_data;

    assign req_data.req_type      = req.req_type;
    assign req_data.reg_a         = req.reg_a;
    assign req_data.reg_b         = req.reg_b;
    assign req_data.operand_value = req.operand_value;
    assign req_data.shift_amount  = req.shift_amount;
    assign req_data.mem_address   = req.mem_address;
    assign req_data.branch_target = req.branch_target;

    assign rsp.read_data      = rsp_data.read_data;
    assign rsp.branch_taken   = rsp_data.branch_taken;
    assign rsp.target_address = rsp_data.target_address;
    assign rsp.error          = rsp_data.error;

    rfx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rfx_datapath #(
        .NUM_REGS  (NUM_REGS),
        .MEM_WORDS (MEM_WORDS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .req    (req_data),
        .rsp    (rsp_data)
    );

    `RFX_ASSERT_SAME(a_err_result, clk, rst_n, rsp.valid && rsp.error, rsp.read_data == -32'sd1 && !rsp.branch_taken && rsp.target_address == 16'd0, "error result not all ones")
    `RFX_ASSERT_SAME(a_target_zero, clk, rst_n, rsp.valid && !rsp.branch_taken, rsp.target_address == 16'd0, "target set without taken branch")
    `RFX_ASSERT_SAME(a_no_req_in_clear, clk, rst_n, cmd.clear_step, !req.ready, "request taken during memory clear")
    `RFX_ASSERT_NEXT(a_out_load_valid, clk, rst_n, cmd.out_load, rsp.valid, "loaded result not presented")

endmodule

// ----- sim/register_file_with_execute_ops_checker.sv -----
// ----------------------------------------------------------------------------
// register_file_with_execute_ops_checker
// watches both channels, keeps its own copy of the registers and data memory,
// predicts the result of every request and compares it with the block
// ----------------------------------------------------------------------------
module register_file_with_execute_ops_checker (
    input  logic clk,
    input  logic rst_n,
    rfx_req_if   req,
    rfx_rsp_if   rsp,
    output int   mismatches,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rfx_pkg::*;

    localparam int NREG = NUM_REGS_DEFAULT;
    localparam int MEMW = MEM_WORDS_DEFAULT;

    logic [31:0] shadow_regs [NREG];
    logic [31:0] shadow_mem  [MEMW];
    rsp_t        result_q [$];

    // applies one request to the shadow state and returns its result
    function automatic rsp_t execute_req(req_t r);
        rsp_t        o;
        logic [31:0] a_val;
        int unsigned addr;
        bit          bad;
        o = '0;
        if (r.req_type > OP_JR)
            return o;
        bad = (r.reg_a >= NREG) ||
              ((r.req_type == OP_BEQ || r.req_type == OP_BNE) && r.reg_b >= NREG);
        if (bad)
        begin
            o.error     = 1'b1;
            o.read_data = -1;
            return o;
        end
        addr  = r.mem_address % MEMW;
        a_val = shadow_regs[r.reg_a];
        case (op_t'(r.req_type))
            OP_WRITE: shadow_regs[r.reg_a] = r.operand_value;
            OP_READ:  o.read_data = a_val;
            OP_STORE: shadow_mem[addr] = a_val;
            OP_LOAD:  shadow_regs[r.reg_a] = shadow_mem[addr];
            OP_ADDI:  shadow_regs[r.reg_a] = a_val + r.operand_value;
            OP_SLL:   shadow_regs[r.reg_a] = a_val << r.shift_amount;
            OP_SRL:   shadow_regs[r.reg_a] = $signed(a_val) >>> r.shift_amount;
            OP_BEQ:   o.branch_taken = (a_val == shadow_regs[r.reg_b]);
            OP_BNE:   o.branch_taken = (a_val != shadow_regs[r.reg_b]);
            OP_JR:    o.read_data = a_val;
            default:  o = '0;
        endcase
        if (o.branch_taken)
            o.target_address = r.branch_target;
        return o;
    endfunction

    task automatic report(string what, rsp_t e, rsp_t g);
        mismatches = mismatches + 1;
        if (mismatches <= 10)
            $display("%0t %s: expected data=%h taken=%b target=%h error=%b, got data=%h taken=%b target=%h error=%b",
                     $realtime, what, e.read_data, e.branch_taken, e.target_address, e.error,
                     g.read_data, g.branch_taken, g.target_address, g.error);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        req_t r;
        rsp_t got;
        rsp_t exp_rsp;
        if (!rst_n)
        begin
            result_q.delete();
            mismatches = 0;
            for (int i = 0; i < NREG; i++)
                shadow_regs[i] = '0;
            for (int i = 0; i < MEMW; i++)
                shadow_mem[i] = '0;
        end
        else
        begin
            // results first: a result never belongs to a request of the same edge
            if (rsp.valid && rsp.ready)
            begin
                got.read_data      = rsp.read_data;
                got.branch_taken   = rsp.branch_taken;
                got.target_address = rsp.target_address;
                got.error          = rsp.error;
                if (result_q.size() == 0)
                    report("unexpected result", '0, got);
                else
                begin
                    exp_rsp = result_q.pop_front();
                    if (got.read_data !== exp_rsp.read_data ||
                        got.branch_taken !== exp_rsp.branch_taken ||
                        got.target_address !== exp_rsp.target_address ||
                        got.error !== exp_rsp.error)
                        report("result mismatch", exp_rsp, got);
                end
            end
            if (req.valid && req.ready)
            begin
                r.req_type      = req.req_type;
                r.reg_a         = req.reg_a;
                r.reg_b         = req.reg_b;
                r.operand_value = req.operand_value;
                r.shift_amount  = req.shift_amount;
                r.mem_address   = req.mem_address;
                r.branch_target = req.branch_target;
                result_q.push_back(execute_req(r));
            end
        end
        pending = result_q.size();
    end

endmodule

// ----- sim/register_file_with_execute_ops_test.sv -----
// ----------------------------------------------------------------------------
// register_file_with_execute_ops_test
// drives directed and random requests with random gaps on both channels,
// including one long result stall, and reports the checker's verdict
// ----------------------------------------------------------------------------
module register_file_with_execute_ops_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rfx_pkg::*;

    localparam logic [3:0] OP_UNUSED_LO = 4'd10;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;
    localparam int RANDOM_REQS   = 680;
    localparam int STALL_AT      = 60;
    localparam int STALL_CYCLES  = 200;
    localparam int DRAIN_CYCLES  = 20;
    // memory clear after reset plus the long stall, with margin
    localparam int IDLE_LIMIT    = 5000;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   idle_cycles;
    int   results_seen;

    rfx_req_if req_ch ();
    rfx_rsp_if rsp_ch ();

    register_file_with_execute_ops dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    register_file_with_execute_ops_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // no transfer on either channel for too long ends the run
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("register_file_with_execute_ops regression: fail");
            $finish;
        end
    end

    task automatic send_req(logic [3:0] op, logic [5:0] a, logic [5:0] b,
                            logic [31:0] v, logic [4:0] sh, logic [9:0] addr,
                            logic [15:0] tgt, int gap);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= op;
        req_ch.reg_a         <= a;
        req_ch.reg_b         <= b;
        req_ch.operand_value <= v;
        req_ch.shift_amount  <= sh;
        req_ch.mem_address   <= addr;
        req_ch.branch_target <= tgt;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    function automatic logic [5:0] pick_reg();
        if ($urandom_range(0, 9) == 0)
            return 6'($urandom_range(NUM_REGS_DEFAULT, 63));
        if ($urandom_range(0, 1) == 0)
            return 6'($urandom_range(0, 7));
        return 6'($urandom_range(0, NUM_REGS_DEFAULT - 1));
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 3);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default:
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0;
                endcase
        endcase
    endfunction

    // result side: random stalls, quiet stretches and one long hold-off
    initial
    begin
        int  gap;
        bit  steady;
        bit  stalled;
        steady       = 1'b0;
        stalled      = 1'b0;
        results_seen = 0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                steady = !steady;
            gap = steady ? 0 : $urandom_range(0, 10);
            if (!stalled && results_seen == STALL_AT)
            begin
                stalled = 1'b1;
                gap     = STALL_CYCLES;
            end
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            results_seen++;
        end
    end

    initial
    begin
        int          gap;
        bit          steady;
        logic [3:0]  op;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= OP_WRITE;
        req_ch.reg_a         <= '0;
        req_ch.reg_b         <= '0;
        req_ch.operand_value <= '0;
        req_ch.shift_amount  <= '0;
        req_ch.mem_address   <= '0;
        req_ch.branch_target <= '0;
        rst_n                 = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every operation, errors and unused codes
        send_req(OP_WRITE, 6'd0,  6'd0,  32'h7FFF_FFFF, 5'd0,  10'd0,    16'h0,    0);
        send_req(OP_WRITE, 6'd31, 6'd0,  32'h8000_0000, 5'd0,  10'd0,    16'h0,    0);
        send_req(OP_ADDI,  6'd0,  6'd0,  32'h0000_0001, 5'd0,  10'd0,    16'h0,    1);
        send_req(OP_ADDI,  6'd31, 6'd0,  32'hFFFF_FFFF, 5'd0,  10'd0,    16'h0,    0);
        send_req(OP_READ,  6'd0,  6'd0,  32'h0,         5'd0,  10'd0,    16'h0,    0);
        send_req(OP_READ,  6'd31, 6'd0,  32'h0,         5'd0,  10'd0,    16'h0,    2);
        send_req(OP_WRITE, 6'd1,  6'd0,  32'hFFFF_FFF8, 5'd0,  10'd0,    16'h0,    0);
        send_req(OP_SRL,   6'd1,  6'd0,  32'h0,         5'd31, 10'd0,    16'h0,    0);
        send_req(OP_WRITE, 6'd2,  6'd0,  32'h0000_0003, 5'd0,  10'd0,    16'h0,    0);
        send_req(OP_SLL,   6'd2,  6'd0,  32'h0,         5'd31, 10'd0,    16'h0,    3);
        send_req(OP_SRL,   6'd2,  6'd0,  32'h0,         5'd0,  10'd0,    16'h0,    0);
        send_req(OP_STORE, 6'd2,  6'd0,  32'h0,         5'd0,  10'd1023, 16'h0,    0);
        send_req(OP_LOAD,  6'd3,  6'd0,  32'h0,         5'd0,  10'd1023, 16'h0,    0);
        send_req(OP_LOAD,  6'd4,  6'd0,  32'h0,         5'd0,  10'd0,    16'h0,    0);
        send_req(OP_BEQ,   6'd3,  6'd2,  32'h0,         5'd0,  10'd0,    16'hFFFF, 0);
        send_req(OP_BNE,   6'd3,  6'd2,  32'h0,         5'd0,  10'd0,    16'hFFFF, 0);
        send_req(OP_BNE,   6'd0,  6'd1,  32'h0,         5'd0,  10'd0,    16'h0,    0);
        send_req(OP_JR,    6'd3,  6'd0,  32'h0,         5'd0,  10'd0,    16'h0,    0);
        send_req(OP_READ,  6'd32, 6'd0,  32'h0,         5'd0,  10'd0,    16'h0,    0);
        send_req(OP_WRITE, 6'd63, 6'd0,  32'h1234_5678, 5'd0,  10'd0,    16'h0,    0);
        send_req(OP_BEQ,   6'd0,  6'd63, 32'h0,         5'd0,  10'd0,    16'hFFFF, 0);
        send_req(OP_STORE, 6'd40, 6'd1,  32'h0,         5'd0,  10'd5,    16'h0,    0);
        send_req(OP_UNUSED_LO, 6'd1, 6'd2, 32'hFFFF_FFFF, 5'd31, 10'd1023, 16'hFFFF, 0);
        send_req(OP_UNUSED_HI, 6'd0, 6'd0, 32'h0,       5'd0,  10'd0,    16'h0,    0);

        // random: mostly valid operations on a few busy registers and words
        steady = 1'b0;
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                steady = !steady;
            gap = steady ? 0 : $urandom_range(0, 10);
            if ($urandom_range(0, 19) == 0)
                op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            else
                op = 4'($urandom_range(OP_WRITE, OP_JR));
            send_req(op, pick_reg(), pick_reg(), pick_value(), 5'($urandom_range(0, 31)),
                     ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 7))
                                                 : 10'($urandom_range(0, 1023)),
                     16'($urandom_range(0, 65535)), gap);
        end
        req_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("register_file_with_execute_ops regression: pass");
        else
            $display("register_file_with_execute_ops regression: fail");
        $finish;
    end

endmodule
